FILE: rtl/core/bip_pkg.sv
package bip_pkg;

    // Default field widths of the block.
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int IOU_FRAC_BITS_DEF = 16;

    // Control group that travels with every item down the pipeline.
    typedef struct packed {
        logic valid;  // stage holds an item
        logic hit;    // overlap width and height are both positive
        logic same;   // union equals intersection, so IoU is exactly one
    } t_ctl;

endpackage

FILE: rtl/core/box_pair_iou.sv
// Pipeline: four front-end stages, one divider stage per quotient bit and the output
// register lie between the edge that takes an item and the edge that takes its result.
// Throughput: one item per cycle while busy is low, with no stall path since the
// receiver always takes the result.
// Reset: synchronous, active low; it clears every valid bit and holds busy high.
module box_pair_iou #(
    parameter int COORD_WIDTH   = bip_pkg::COORD_WIDTH_DEF,
    parameter int IOU_FRAC_BITS = bip_pkg::IOU_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a_left,
    input  logic signed [COORD_WIDTH-1:0] i_a_top,
    input  logic signed [COORD_WIDTH-1:0] i_a_right,
    input  logic signed [COORD_WIDTH-1:0] i_a_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_b_left,
    input  logic signed [COORD_WIDTH-1:0] i_b_top,
    input  logic signed [COORD_WIDTH-1:0] i_b_right,
    input  logic signed [COORD_WIDTH-1:0] i_b_bottom,
    output logic                          o_valid,
    output logic [IOU_FRAC_BITS:0]        o_iou,
    output logic                          o_overlaps
);
    import bip_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = IOU_FRAC_BITS;
    localparam int LAT = F + 5;

    // Busy is registered: set by reset and cleared by the first clock edge with reset released.
    logic r_busy;
    logic n_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign n_accept = start && !r_busy;

    // Geometry, areas and union.
    t_ctl            w_front_ctl;
    logic [2*CW-1:0] w_inter;
    logic [2*CW:0]   w_union;

    bip_front #(
        .CW (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (n_accept),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_right  (i_a_right),
        .i_a_bottom (i_a_bottom),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_right  (i_b_right),
        .i_b_bottom (i_b_bottom),
        .o_ctl      (w_front_ctl),
        .o_inter    (w_inter),
        .o_union    (w_union)
    );

    // Pipelined fraction divider.
    t_ctl         w_div_ctl;
    logic [F-1:0] w_quo;

    bip_div #(
        .CW (CW),
        .F  (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_front_ctl),
        .i_inter (w_inter),
        .i_union (w_union),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_quo)
    );

    // Output register: zero when no overlap, exactly one for equal boxes.
    logic         r_valid;
    logic [F:0]   r_iou;
    logic         r_overlaps;
    logic [F:0]   n_iou;

    always_comb begin
        if (!w_div_ctl.hit) begin
            n_iou = '0;
        end else if (w_div_ctl.same) begin
            n_iou = {1'b1, {F{1'b0}}};
        end else begin
            n_iou = {1'b0, w_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iou      <= n_iou;
        r_overlaps <= w_div_ctl.hit;
    end

    assign o_valid    = r_valid;
    assign o_iou      = r_iou;
    assign o_overlaps = r_overlaps;

    // Every result belongs to an item taken a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(n_accept, LAT))
        else $error("result without a matching item");

    // Non-overlapping boxes always give zero.
    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overlaps) |-> (o_iou == '0))
        else $error("nonzero IoU without overlap");

    // IoU never exceeds one.
    a_at_most_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_iou <= {1'b1, {F{1'b0}}}))
        else $error("IoU above one");

endmodule

FILE: rtl/core/bip_front.sv
module bip_front #(
    parameter int CW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [CW-1:0]   i_a_left,
    input  logic signed [CW-1:0]   i_a_top,
    input  logic signed [CW-1:0]   i_a_right,
    input  logic signed [CW-1:0]   i_a_bottom,
    input  logic signed [CW-1:0]   i_b_left,
    input  logic signed [CW-1:0]   i_b_top,
    input  logic signed [CW-1:0]   i_b_right,
    input  logic signed [CW-1:0]   i_b_bottom,
    output bip_pkg::t_ctl          o_ctl,
    output logic [2*CW-1:0]        o_inter,
    output logic [2*CW:0]          o_union
);
    import bip_pkg::*;

    localparam int PW = 2 * CW;
    localparam int UW = 2 * CW + 1;

    // Stage 1: overlap extents and box extents.
    logic signed [CW:0] n_al, n_at, n_ar, n_ab, n_bl, n_bt, n_br, n_bb;
    logic signed [CW:0] n_lmax, n_tmax, n_rmin, n_bmin, n_w, n_h;
    logic signed [CW:0] n_aw, n_ah, n_bw, n_bh;
    logic               n_hit;

    always_comb begin
        n_al = $signed({i_a_left[CW-1], i_a_left});
        n_at = $signed({i_a_top[CW-1], i_a_top});
        n_ar = $signed({i_a_right[CW-1], i_a_right});
        n_ab = $signed({i_a_bottom[CW-1], i_a_bottom});
        n_bl = $signed({i_b_left[CW-1], i_b_left});
        n_bt = $signed({i_b_top[CW-1], i_b_top});
        n_br = $signed({i_b_right[CW-1], i_b_right});
        n_bb = $signed({i_b_bottom[CW-1], i_b_bottom});
        n_lmax = (n_al > n_bl) ? n_al : n_bl;
        n_tmax = (n_at > n_bt) ? n_at : n_bt;
        n_rmin = (n_ar < n_br) ? n_ar : n_br;
        n_bmin = (n_ab < n_bb) ? n_ab : n_bb;
        n_w  = n_rmin - n_lmax;
        n_h  = n_bmin - n_tmax;
        n_aw = n_ar - n_al;
        n_ah = n_ab - n_at;
        n_bw = n_br - n_bl;
        n_bh = n_bb - n_bt;
        // Positive means sign clear and not zero.
        n_hit = !n_w[CW] && (n_w != '0) && !n_h[CW] && (n_h != '0);
    end

    // When the overlap is positive every extent lies in 1 .. 2^CW-1.
    t_ctl          r_ctl1;
    logic [CW-1:0] r_w, r_h, r_aw, r_ah, r_bw, r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= '{valid: i_valid, hit: n_hit, same: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_w  <= n_w[CW-1:0];
        r_h  <= n_h[CW-1:0];
        r_aw <= n_aw[CW-1:0];
        r_ah <= n_ah[CW-1:0];
        r_bw <= n_bw[CW-1:0];
        r_bh <= n_bh[CW-1:0];
    end

    // Stage 2: intersection and the two box areas.
    t_ctl          r_ctl2;
    logic [PW-1:0] r_inter2, r_area_a, r_area_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inter2 <= r_w * r_h;
        r_area_a <= r_aw * r_ah;
        r_area_b <= r_bw * r_bh;
    end

    // Stage 3: sum of the areas with one carry bit.
    t_ctl          r_ctl3;
    logic [PW-1:0] r_inter3;
    logic [UW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else begin
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inter3 <= r_inter2;
        r_sum    <= {1'b0, r_area_a} + {1'b0, r_area_b};
    end

    // Stage 4: union, and the check for a union equal to the intersection.
    t_ctl          r_ctl4;
    logic [PW-1:0] r_inter4;
    logic [UW-1:0] r_union;
    logic          n_same;

    assign n_same = (r_sum == {r_inter3, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
        end else begin
            r_ctl4 <= '{valid: r_ctl3.valid, hit: r_ctl3.hit, same: n_same};
        end
    end

    always_ff @(posedge i_clk) begin
        r_inter4 <= r_inter3;
        r_union  <= r_sum - {1'b0, r_inter3};
    end

    assign o_ctl   = r_ctl4;
    assign o_inter = r_inter4;
    assign o_union = r_union;

    // An item leaves the front end only after passing through every front-end stage register.
    a_front_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl4.valid |-> $past(i_valid, 4))
        else $error("front end produced an item that never entered");

    // Whenever boxes overlap, the union covers the intersection.
    a_union_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl4.valid && r_ctl4.hit) |-> (r_union >= {1'b0, r_inter4}))
        else $error("union smaller than intersection");

    // A set same flag means the boxes overlap or the union equals the intersection.
    a_same_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl4.valid && r_ctl4.same) |-> (r_ctl4.hit || r_union == {1'b0, r_inter4}))
        else $error("same flag set without equal union");

endmodule

FILE: rtl/core/bip_div.sv
module bip_div #(
    parameter int CW = 16,
    parameter int F  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bip_pkg::t_ctl        i_ctl,
    input  logic [2*CW-1:0]      i_inter,
    input  logic [2*CW:0]        i_union,
    output bip_pkg::t_ctl        o_ctl,
    output logic [F-1:0]         o_quo
);
    import bip_pkg::*;

    localparam int UW = 2 * CW + 1;

    // One restoring quotient bit per stage; for IoU below one, remainder < union.
    t_ctl          r_ctl [F];
    logic [UW-1:0] r_rem [F];
    logic [UW-1:0] r_uni [F];
    logic [F-1:0]  r_quo [F];

    for (genvar k = 0; k < F; k++) begin : g_step
        t_ctl          p_ctl;
        logic [UW-1:0] p_rem, p_uni;
        logic [F-1:0]  p_quo;
        logic [UW:0]   n_shift, n_diff;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign p_ctl = i_ctl;
            assign p_rem = {1'b0, i_inter};
            assign p_uni = i_union;
            assign p_quo = '0;
        end else begin : g_next
            assign p_ctl = r_ctl[k-1];
            assign p_rem = r_rem[k-1];
            assign p_uni = r_uni[k-1];
            assign p_quo = r_quo[k-1];
        end

        // Shift the partial remainder and try to subtract the union.
        always_comb begin
            n_shift = {p_rem, 1'b0};
            n_ge    = (n_shift >= {1'b0, p_uni});
            n_diff  = n_shift - {1'b0, p_uni};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? n_diff[UW-1:0] : n_shift[UW-1:0];
            r_uni[k] <= p_uni;
            r_quo[k] <= {p_quo[F-2:0], n_ge};
        end
    end

    assign o_ctl = r_ctl[F-1];
    assign o_quo = r_quo[F-1];

    // Items take one stage per quotient bit.
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[F-1].valid |-> $past(i_ctl.valid, F))
        else $error("divider produced an item that never entered");

    // For a true fraction the final remainder must stay below the union.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[F-1].valid && r_ctl[F-1].hit && !r_ctl[F-1].same)
            |-> (r_rem[F-1] < r_uni[F-1]))
        else $error("divider remainder out of range");

    // Flags pass through the divider unchanged.
    a_flags_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[F-1].valid |-> (r_ctl[F-1].hit == $past(i_ctl.hit, F)))
        else $error("overlap flag changed inside divider");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bip_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = IOU_FRAC_BITS_DEF;
    localparam int RANDOM_PER_PHASE = 295;
    localparam int SETTLE_CYCLES = FB + 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord a_left;
        t_coord a_top;
        t_coord a_right;
        t_coord a_bottom;
        t_coord b_left;
        t_coord b_top;
        t_coord b_right;
        t_coord b_bottom;
    } t_box_pair;

    typedef struct packed {
        logic [FB:0] iou;
        logic        overlaps;
    } t_iou_res;

    typedef struct {
        t_box_pair pair;
        logic      typed;
        t_iou_res  res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_box_pair pair_d;
    logic typed_d;
    t_iou_res typed_res_d;
    logic o_valid;
    logic [FB:0] o_iou;
    logic o_overlaps;

    t_iou_res iou_pending[$];
    t_dir_row dir_rows[$];
    int fails = 0;
    int items_taken = 0;
    int results_seen = 0;
    int overlap_seen = 0;
    int unity_seen = 0;
    int cycles = 0;

    box_pair_iou dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_a_left   (pair_d.a_left),
        .i_a_top    (pair_d.a_top),
        .i_a_right  (pair_d.a_right),
        .i_a_bottom (pair_d.a_bottom),
        .i_b_left   (pair_d.b_left),
        .i_b_top    (pair_d.b_top),
        .i_b_right  (pair_d.b_right),
        .i_b_bottom (pair_d.b_bottom),
        .o_valid    (o_valid),
        .o_iou      (o_iou),
        .o_overlaps (o_overlaps)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact integer IoU of one box pair, quotient truncated to FB fraction bits.
    function automatic t_iou_res predict_iou(t_box_pair p);
        longint al, at, ar, ab, bl, bt, br, bb, wd, ht;
        logic [63:0] inter, area_a, area_b, uni, quot;
        t_iou_res r;
        al = $signed(p.a_left);
        at = $signed(p.a_top);
        ar = $signed(p.a_right);
        ab = $signed(p.a_bottom);
        bl = $signed(p.b_left);
        bt = $signed(p.b_top);
        br = $signed(p.b_right);
        bb = $signed(p.b_bottom);
        wd = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        ht = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        r = '0;
        if (wd > 0 && ht > 0) begin
            // A positive overlap means both boxes are well formed.
            inter = wd * ht;
            area_a = (ar - al) * (ab - at);
            area_b = (br - bl) * (bb - bt);
            uni = area_a + area_b - inter;
            quot = (inter << FB) / uni;
            r.iou = quot[FB:0];
            r.overlaps = 1'b1;
        end
        return r;
    endfunction

    function automatic t_box_pair mk_pair(int al, int at, int ar, int ab,
                                          int bl, int bt, int br, int bb);
        t_box_pair p;
        p.a_left = al[CW-1:0];
        p.a_top = at[CW-1:0];
        p.a_right = ar[CW-1:0];
        p.a_bottom = ab[CW-1:0];
        p.b_left = bl[CW-1:0];
        p.b_top = bt[CW-1:0];
        p.b_right = br[CW-1:0];
        p.b_bottom = bb[CW-1:0];
        return p;
    endfunction

    task automatic add_row(t_box_pair p, logic typed, int iou, logic ovl);
        t_dir_row row;
        row.pair = p;
        row.typed = typed;
        row.res.iou = iou[FB:0];
        row.res.overlaps = ovl;
        dir_rows.push_back(row);
    endtask

    // One well-formed interval inside [base, base + span].
    function automatic void pick_span(int base, int span, output int lo, output int hi);
        lo = base + $urandom_range(span - 1);
        hi = lo + 1 + $urandom_range(base + span - lo - 1);
    endfunction

    // Random box pair: mostly nearby well-formed boxes, plus identical,
    // raw, extreme-valued and inverted pairs.
    function automatic t_box_pair rand_pair();
        t_box_pair p;
        int mode, span, bx, by, tmp;
        int xl0, xh0, yl0, yh0, xl1, xh1, yl1, yh1;
        int ext[7];
        ext = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        mode = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? $urandom_range(65535, 2) : $urandom_range(200, 2);
        bx = $urandom_range(65535 - span) - 32768;
        by = $urandom_range(65535 - span) - 32768;
        pick_span(bx, span, xl0, xh0);
        pick_span(by, span, yl0, yh0);
        pick_span(bx, span, xl1, xh1);
        pick_span(by, span, yl1, yh1);
        if (mode < 15) begin
            p = mk_pair(xl0, yl0, xh0, yh0, xl0, yl0, xh0, yh0);
        end else if (mode < 25) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else if (mode < 35) begin
            p = mk_pair(ext[$urandom_range(6)], ext[$urandom_range(6)],
                        ext[$urandom_range(6)], ext[$urandom_range(6)],
                        ext[$urandom_range(6)], ext[$urandom_range(6)],
                        ext[$urandom_range(6)], ext[$urandom_range(6)]);
        end else if (mode < 45) begin
            // Turn one side of one box inside out.
            case ($urandom_range(3))
                0: begin tmp = xl0; xl0 = xh0; xh0 = tmp; end
                1: begin tmp = yl0; yl0 = yh0; yh0 = tmp; end
                2: begin tmp = xl1; xl1 = xh1; xh1 = tmp; end
                default: begin tmp = yl1; yl1 = yh1; yh1 = tmp; end
            endcase
            p = mk_pair(xl0, yl0, xh0, yh0, xl1, yl1, xh1, yh1);
        end else begin
            p = mk_pair(xl0, yl0, xh0, yh0, xl1, yl1, xh1, yh1);
        end
        return p;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_pair(t_box_pair p, logic typed, t_iou_res res);
        start <= 1'b1;
        pair_d <= p;
        typed_d <= typed;
        typed_res_d <= res;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Random idle cycles with noise on the coordinate ports.
    task automatic idle_gaps(int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            pair_d <= {$urandom, $urandom, $urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    // Record each accepted item and check each result against the oldest one.
    always @(posedge i_clk) begin
        t_iou_res want;
        if (i_rst_n) begin
            if (start && !busy) begin
                iou_pending.push_back(typed_d ? typed_res_d : predict_iou(pair_d));
                items_taken++;
            end
            if ($isunknown(o_valid)) begin
                $display("%0t: result strobe is unknown", $time);
                fails++;
            end else if (o_valid) begin
                results_seen++;
                if (iou_pending.size() == 0) begin
                    $display("%0t: result with none pending: iou %0d overlaps %0b",
                             $time, o_iou, o_overlaps);
                    fails++;
                end else begin
                    want = iou_pending.pop_front();
                    if (o_iou !== want.iou) begin
                        $display("%0t: iou expected %0d got %0d", $time, want.iou, o_iou);
                        fails++;
                    end
                    if (o_overlaps !== want.overlaps) begin
                        $display("%0t: overlaps expected %0b got %0b",
                                 $time, want.overlaps, o_overlaps);
                        fails++;
                    end
                    if (want.overlaps) overlap_seen++;
                    if (want.iou == (1 << FB)) unity_seen++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results pending",
                     $time, cycles, iou_pending.size());
            $display("box_pair_iou: mismatch");
            $finish;
        end
    end

    // Reset, directed table, then random phases with different sender idling.
    initial begin
        t_iou_res none;
        int idle_pct[3];
        none = '0;
        idle_pct = '{0, 84, 30};
        start <= 1'b0;
        pair_d <= '0;
        typed_d <= 1'b0;
        typed_res_d <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identical boxes give exactly one, at normal and full range.
        add_row(mk_pair(0, 0, 256, 256, 0, 0, 256, 256), 1'b1, 1 << FB, 1'b1);
        add_row(mk_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767),
                1'b1, 1 << FB, 1'b1);
        add_row(mk_pair(-100, -50, -20, -10, -100, -50, -20, -10), 1'b1, 1 << FB, 1'b1);
        add_row(mk_pair(-32768, 0, 32767, 1, -32768, 0, 32767, 1), 1'b1, 1 << FB, 1'b1);
        // Disjoint and edge-touching boxes have no overlap.
        add_row(mk_pair(0, 0, 16, 16, 32, 0, 48, 16), 1'b1, 0, 1'b0);
        add_row(mk_pair(0, 0, 16, 16, 16, 0, 32, 16), 1'b1, 0, 1'b0);
        add_row(mk_pair(0, 0, 16, 16, 0, 16, 16, 32), 1'b1, 0, 1'b0);
        add_row(mk_pair(0, 0, 16, 16, 8, 32, 24, 48), 1'b1, 0, 1'b0);
        // Inverted and empty boxes never overlap.
        add_row(mk_pair(16, 0, 0, 16, 0, 0, 16, 16), 1'b1, 0, 1'b0);
        add_row(mk_pair(0, 0, 16, 16, 0, 16, 16, 0), 1'b1, 0, 1'b0);
        add_row(mk_pair(8, 0, 8, 16, 0, 0, 16, 16), 1'b1, 0, 1'b0);
        add_row(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
                1'b1, 0, 1'b0);
        add_row(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                1'b1, 0, 1'b0);
        // A box inside another covering a quarter of it.
        add_row(mk_pair(0, 0, 64, 64, 16, 16, 48, 48), 1'b1, 1 << (FB - 2), 1'b1);
        // Partial overlaps, a tiny overlap on the widest box, alternating bits.
        add_row(mk_pair(0, 0, 32, 16, 16, 0, 48, 16), 1'b0, 0, 1'b0);
        add_row(mk_pair(-32768, -32768, 32767, 32767, 32766, 32766, 32767, 32767),
                1'b0, 0, 1'b0);
        add_row(mk_pair(-21846, -21846, 21845, 21845, -1000, -1000, 21845, 21845),
                1'b0, 0, 1'b0);
        add_row(mk_pair(0, 0, 3, 1, 1, 0, 4, 1), 1'b0, 0, 1'b0);

        foreach (dir_rows[i]) begin
            send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].res);
        end

        foreach (idle_pct[ph]) begin
            repeat (RANDOM_PER_PHASE) begin
                idle_gaps(idle_pct[ph]);
                send_pair(rand_pair(), 1'b0, none);
            end
        end
        start <= 1'b0;

        // Drain the pipeline, then watch for stray results.
        while (iou_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d box pairs (%0d directed) under three idling phases.",
                 items_taken, dir_rows.size());
        $display("Checked %0d results: %0d overlapping, %0d with IoU of exactly one.",
                 results_seen, overlap_seen, unity_seen);
        if (fails == 0) begin
            $display("box_pair_iou: match");
        end else begin
            $display("box_pair_iou: mismatch");
        end
        $finish;
    end

endmodule
